### hw/rtl/tmc_pkg.sv
// Shared types and constants for the TCP MSS clamp unit.
// No dependencies; every module of the block imports this package.
package tmc_pkg;

  // Configuration register indexes on the APB port.
  localparam int unsigned RegClampEnable = 0;
  localparam int unsigned RegTargetMss   = 1;
  localparam int unsigned RegIpv6Mode    = 2;
  localparam int unsigned RegSynOnly     = 3;

  // Register reset values.
  localparam logic [15:0] TargetMssReset = 16'd1460;

  // Default depth of the result queue (must be 2 or more).
  localparam int unsigned ResFifoDepth = 4;

  // One result byte as it leaves the block.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       clamped;
  } tmc_res_t;

  // Up to two results produced by one input byte, in order.
  typedef struct packed {
    logic [1:0] cnt;
    tmc_res_t   r0;
    tmc_res_t   r1;
  } tmc_push_t;

  // Configuration as seen by the parser.
  typedef struct packed {
    logic        clamp_enable;
    logic [15:0] mss_cap;
    logic        ipv6_mode;
    logic        syn_only;
  } tmc_cfg_t;

endpackage

### hw/rtl/tmc_if.sv
// Valid/ready stream interfaces for segment bytes in and result bytes out.
// Depends on nothing.
interface tmc_seg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  seg_byte;
  logic        first_byte;
  logic        last_byte;
  logic [15:0] seg_length;

  modport source (output valid, seg_byte, first_byte, last_byte, seg_length, input ready);
  modport sink   (input valid, seg_byte, first_byte, last_byte, seg_length, output ready);
endinterface

interface tmc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       clamped;

  modport source (output valid, out_byte, out_last, clamped, input ready);
  modport sink   (input valid, out_byte, out_last, clamped, output ready);
endinterface

### hw/rtl/tcp_mss_clamp_unit.sv
// TCP MSS clamp unit: one byte per transfer in, one result byte per transfer
// out. A new segment byte is accepted every cycle while the result queue has
// room for two results; each byte is parsed in the cycle it is accepted and
// its results are queued. The high byte of an MSS option value is held back
// and leaves with the low byte, so that item gives no result and the next
// gives two; the output side therefore sets the long-run rate to one result
// per cycle while res_o is ready. Configuration goes through the APB port
// at byte addresses 0, 4, 8 and 12 and should be written between segments.
// Depends on tmc_pkg, tmc_if, tmc_parser and tmc_res_fifo.
module tcp_mss_clamp_unit
  import tmc_pkg::*;
#(
  parameter int unsigned FifoDepth = ResFifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tmc_seg_if.sink     seg_i,
  tmc_res_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        clamp_enable_q;
  logic [15:0] mss_cap_q;
  logic        ipv6_mode_q;
  logic        syn_only_q;
  logic        cfg_wr;
  logic        take;
  logic        room;
  tmc_cfg_t    cfg;
  tmc_push_t   push;
  tmc_res_t    head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_enable_q <= 1'b1;
      mss_cap_q      <= TargetMssReset;
      ipv6_mode_q    <= 1'b0;
      syn_only_q     <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        2'(RegClampEnable): clamp_enable_q <= pwdata[0];
        2'(RegTargetMss):   mss_cap_q      <= pwdata[15:0];
        2'(RegIpv6Mode):    ipv6_mode_q    <= pwdata[0];
        2'(RegSynOnly):     syn_only_q     <= pwdata[0];
        default:            clamp_enable_q <= clamp_enable_q;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (paddr[3:2])
      2'(RegClampEnable): prdata = {31'd0, clamp_enable_q};
      2'(RegTargetMss):   prdata = {16'd0, mss_cap_q};
      2'(RegIpv6Mode):    prdata = {31'd0, ipv6_mode_q};
      2'(RegSynOnly):     prdata = {31'd0, syn_only_q};
      default:            prdata = 32'd0;
    endcase
  end

  assign cfg = '{clamp_enable: clamp_enable_q, mss_cap: mss_cap_q,
                 ipv6_mode: ipv6_mode_q, syn_only: syn_only_q};

  // Input transfer handshake.
  assign seg_i.ready = room;
  assign take        = seg_i.valid && room;

  tmc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .take_i       (take),
    .seg_byte_i   (seg_i.seg_byte),
    .first_byte_i (seg_i.first_byte),
    .last_byte_i  (seg_i.last_byte),
    .seg_length_i (seg_i.seg_length),
    .push_o       (push)
  );

  tmc_res_fifo #(
    .Depth (FifoDepth)
  ) u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (take),
    .push_i    (push),
    .room_o    (room),
    .valid_o   (res_o.valid),
    .pop_i     (res_o.ready),
    .data_o    (head)
  );

  assign res_o.out_byte = head.out_byte;
  assign res_o.out_last = head.out_last;
  assign res_o.clamped  = head.clamped;

endmodule

### hw/rtl/tmc_parser.sv
// Per-byte TCP header and option walker that decides the MSS rewrite.
// Depends on tmc_pkg; produces up to two results for each accepted byte.
module tmc_parser
  import tmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tmc_cfg_t    cfg_i,
  input  logic        take_i,
  input  logic [7:0]  seg_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic [15:0] seg_length_i,
  output tmc_push_t   push_o
);

  // Walk phase codes.
  localparam logic [2:0] PhWalk     = 3'd0;
  localparam logic [2:0] PhLenOther = 3'd1;
  localparam logic [2:0] PhLenMss   = 3'd2;
  localparam logic [2:0] PhMssHi    = 3'd3;
  localparam logic [2:0] PhMssLo    = 3'd4;
  localparam logic [2:0] PhDone     = 3'd5;

  localparam logic [5:0]  OptStart  = 6'd20;
  localparam logic [7:0]  MssKind   = 8'h02;
  localparam logic [7:0]  MssLen    = 8'd4;
  localparam logic [15:0] V6Reduce  = 16'd20;

  logic [15:0] idx_q, idx_d;
  logic [5:0]  hdr_q, hdr_d;
  logic        syn_q, syn_d;
  logic [5:0]  nxt_q, nxt_d;
  logic [2:0]  phase_q, phase_d;
  logic [7:0]  held_q, held_d;
  logic        lok_q, lok_d;
  logic [15:0] slen_q, slen_d;

  // Effective state after an optional segment restart.
  logic [15:0] idx_e;
  logic [5:0]  hdr_e, nxt_e;
  logic        syn_e, lok_e;
  logic [2:0]  phase_e;
  logic        flush;

  // Values after the header length and flag bytes are seen.
  logic [5:0]  hdr_n;
  logic        syn_n, lok_n;
  logic        in_opts, active, hold;
  logic [15:0] tgt;
  logic [15:0] cur;
  logic [8:0]  opt_end;
  logic [6:0]  idx_p1;
  logic [1:0]  m_cnt;
  tmc_res_t    m0, m1, fl;

  always_comb begin
    flush   = first_byte_i && (phase_q == PhMssLo);
    idx_e   = first_byte_i ? 16'd0 : idx_q;
    hdr_e   = first_byte_i ? 6'd0 : hdr_q;
    syn_e   = first_byte_i ? 1'b0 : syn_q;
    nxt_e   = first_byte_i ? OptStart : nxt_q;
    phase_e = first_byte_i ? PhWalk : phase_q;
    lok_e   = first_byte_i ? 1'b0 : lok_q;
    slen_d  = first_byte_i ? seg_length_i : slen_q;

    // Header length at offset 12 and SYN flag at offset 13.
    hdr_n = (idx_e == 16'd12) ? {seg_byte_i[7:4], 2'b00} : hdr_e;
    lok_n = (idx_e == 16'd12) ? (slen_d >= {10'd0, hdr_n}) : lok_e;
    syn_n = (idx_e == 16'd13) ? seg_byte_i[1] : syn_e;

    // Effective target and clamp decision for the low MSS byte.
    tgt    = (cfg_i.ipv6_mode && (cfg_i.mss_cap > V6Reduce)) ?
             (cfg_i.mss_cap - V6Reduce) : cfg_i.mss_cap;
    cur    = {held_q, seg_byte_i};
    active = cfg_i.clamp_enable && (hdr_n > OptStart) && lok_n &&
             (!cfg_i.syn_only || syn_n);

    in_opts = (idx_e >= {10'd0, OptStart}) && (idx_e < {10'd0, hdr_n});
    idx_p1  = {1'b0, idx_e[5:0]} + 7'd1;
    opt_end = {3'd0, nxt_e} + {1'b0, seg_byte_i};

    phase_d = phase_e;
    nxt_d   = nxt_e;
    held_d  = first_byte_i ? 8'd0 : held_q;
    hold    = 1'b0;

    fl = '{out_byte: held_q, out_last: 1'b0, clamped: 1'b0};
    m0 = '{out_byte: seg_byte_i, out_last: last_byte_i, clamped: 1'b0};
    m1 = m0;
    m_cnt = 2'd1;

    if (phase_e == PhMssLo) begin
      // Release the held high byte together with the low byte.
      m_cnt = 2'd2;
      if (active && (cur > tgt)) begin
        m0 = '{out_byte: tgt[15:8], out_last: 1'b0, clamped: 1'b1};
        m1 = '{out_byte: tgt[7:0], out_last: last_byte_i, clamped: 1'b1};
      end else begin
        m0 = fl;
        m1 = '{out_byte: seg_byte_i, out_last: last_byte_i, clamped: 1'b0};
      end
      phase_d = PhDone;
    end else if (in_opts && (phase_e != PhDone)) begin
      unique case (phase_e)
        PhWalk: begin
          if (idx_e == {10'd0, nxt_e}) begin
            if (seg_byte_i == 8'd0) begin
              phase_d = PhDone;
            end else if (seg_byte_i == 8'd1) begin
              nxt_d = idx_p1[5:0];
            end else if (idx_p1 >= {1'b0, hdr_n}) begin
              phase_d = PhDone;
            end else begin
              phase_d = (seg_byte_i == MssKind) ? PhLenMss : PhLenOther;
            end
          end
        end
        PhLenOther, PhLenMss: begin
          if ((seg_byte_i < 8'd2) || (opt_end > {3'd0, hdr_n})) begin
            phase_d = PhDone;
          end else if ((phase_e == PhLenMss) && (seg_byte_i == MssLen)) begin
            phase_d = PhMssHi;
          end else begin
            nxt_d   = opt_end[5:0];
            phase_d = PhWalk;
          end
        end
        PhMssHi: begin
          if (last_byte_i) begin
            phase_d = PhDone;
          end else begin
            held_d  = seg_byte_i;
            phase_d = PhMssLo;
            hold    = 1'b1;
          end
        end
        default: begin
          phase_d = PhDone;
        end
      endcase
      if (hold) begin
        m_cnt = 2'd0;
      end
    end

    // Order the flushed byte ahead of this byte's own results.
    if (flush) begin
      push_o.cnt = m_cnt + 2'd1;
      push_o.r0  = fl;
      push_o.r1  = m0;
    end else begin
      push_o.cnt = m_cnt;
      push_o.r0  = m0;
      push_o.r1  = m1;
    end

    // Advance the offset, or restart after the final byte.
    hdr_d = hdr_n;
    syn_d = syn_n;
    lok_d = lok_n;
    idx_d = (idx_e == 16'hFFFF) ? idx_e : idx_e + 16'd1;
    if (last_byte_i) begin
      idx_d   = 16'd0;
      hdr_d   = 6'd0;
      syn_d   = 1'b0;
      nxt_d   = OptStart;
      phase_d = PhWalk;
      held_d  = 8'd0;
      lok_d   = 1'b0;
    end
  end

  // Segment state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 16'd0;
      hdr_q   <= 6'd0;
      syn_q   <= 1'b0;
      nxt_q   <= OptStart;
      phase_q <= PhWalk;
      held_q  <= 8'd0;
      lok_q   <= 1'b0;
      slen_q  <= 16'd0;
    end else if (take_i) begin
      idx_q   <= idx_d;
      hdr_q   <= hdr_d;
      syn_q   <= syn_d;
      nxt_q   <= nxt_d;
      phase_q <= phase_d;
      held_q  <= held_d;
      lok_q   <= lok_d;
      slen_q  <= slen_d;
    end
  end

`ifndef SYNTHESIS
  // A byte that yields no result is always the held high MSS byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && (push_o.cnt == 2'd0)) |=> (phase_q == PhMssLo))
    else $error("tmc_parser: byte swallowed without holding it");

  // A rewritten value always leaves as a complete byte pair.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && push_o.r0.clamped) |-> (push_o.r1.clamped && (push_o.cnt == 2'd2)))
    else $error("tmc_parser: clamped byte without its partner");

  // A new segment while holding flushes the held byte ahead of the new one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && flush) |-> ((push_o.cnt == 2'd2) && !push_o.r0.clamped))
    else $error("tmc_parser: held byte not flushed on segment start");
`endif

endmodule

### hw/rtl/tmc_res_fifo.sv
// Small result queue: takes up to two results per cycle, gives one per pop.
// Depends on tmc_pkg for the result types.
module tmc_res_fifo
  import tmc_pkg::*;
#(
  parameter int unsigned Depth = ResFifoDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_en_i,
  input  tmc_push_t push_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      pop_i,
  output tmc_res_t  data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  tmc_res_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_p1;
  logic [CntW-1:0] cnt_q, cnt_d, n_push;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == LastPtr) ? '0 : p + 1'b1;
  endfunction

  // Room for the largest group of results one byte can cause.
  assign room_o  = (cnt_q <= CntW'(Depth - 2));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign pop     = pop_i && valid_o;

  always_comb begin
    n_push = push_en_i ? CntW'(push_i.cnt) : '0;
    wr_p1  = ptr_inc(wr_q);
    wr_d   = (n_push == CntW'(2)) ? ptr_inc(wr_p1) :
             (n_push == CntW'(1)) ? wr_p1 : wr_q;
    rd_d   = pop ? ptr_inc(rd_q) : rd_q;
    cnt_d  = cnt_q + n_push - CntW'(pop);
  end

  // Storage writes.
  always_ff @(posedge clk_i) begin
    if (n_push != '0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (n_push == CntW'(2)) begin
      mem_q[wr_p1] <= push_i.r1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("tmc_res_fifo: fill level above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_en_i && (push_i.cnt != 2'd0)) |-> room_o)
    else $error("tmc_res_fifo: push without room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (n_push == '0)) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("tmc_res_fifo: pop did not lower fill level");
`endif

endmodule
